// ===== sv/fsk_tape_byte_encoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// FSK tape byte encoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef FSK_TAPE_BYTE_ENCODER_CORE_DEFINES_SVH
`define FSK_TAPE_BYTE_ENCODER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSKENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSKENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fskenc_pkg.sv =====
// ---------------------------------------------------------------------------
// FSK tape byte encoder package
// Widths, tone patterns and the structs shared by the encoder modules.
// ---------------------------------------------------------------------------
package fskenc_pkg;

  // Samples in one line bit and the tone patterns for each bit value.
  // A one is eight periods of two low then two high samples, a zero is four
  // periods of four low then four high samples; bit k is sample k.
  localparam int BIT_SAMPLES = 32;
  localparam logic [BIT_SAMPLES-1:0] ONE_PATTERN  = 32'hCCCC_CCCC;
  localparam logic [BIT_SAMPLES-1:0] ZERO_PATTERN = 32'hF0F0_F0F0;

  // Framing: start zero, eight data bits, two stop ones.
  localparam int FRAME_BITS = 11;
  localparam int MAX_BEATS  = 2 * FRAME_BITS;
  localparam int CNT_W      = $clog2(MAX_BEATS + 1);

  // Check group size limits.
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_MIN = 5'd1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd4;

  // Request kinds.
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  // One result beat.
  typedef struct packed {
    logic [BIT_SAMPLES-1:0] sample_pattern;
    logic                   tone_bit;
    logic                   is_check_byte;
    logic                   last;
  } beat_t;

  // Serializer status seen by the top level.
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] remaining;
  } ser_status_t;

endpackage

// ===== sv/fskenc_serializer.sv =====
// ---------------------------------------------------------------------------
// FSK encoder bit serializer
// Frames a request into line bits, keeps the running check sum and emits
// one tone pattern per line bit.
// ---------------------------------------------------------------------------
module fskenc_serializer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fskenc_pkg::SIZE_W-1:0] check_group_size,
  input  logic                        load,
  input  logic                        req_type,
  input  logic [7:0]                  data_byte,
  input  logic                        advance,
  output fskenc_pkg::ser_status_t     status,
  output fskenc_pkg::beat_t           beat
);

  logic [fskenc_pkg::MAX_BEATS-1:0] frame;
  logic [fskenc_pkg::CNT_W-1:0]     remaining;
  logic                             busy;
  logic                             with_check;
  logic [7:0]                       running_sum;
  logic [3:0]                       group_count;

  logic [fskenc_pkg::SIZE_W-1:0]    eff_size;
  logic [7:0]                       sum_next;
  logic [7:0]                       chk_byte;
  logic                             group_end;
  logic                             beat_last;

  // Clamp the group size to the supported range.
  always_comb begin
    if (check_group_size < fskenc_pkg::SIZE_MIN) begin
      eff_size = fskenc_pkg::SIZE_MIN;
    end else if (check_group_size > fskenc_pkg::SIZE_MAX) begin
      eff_size = fskenc_pkg::SIZE_MAX;
    end else begin
      eff_size = check_group_size;
    end
  end

  // New sum, group end test and the two's complement check byte.
  assign sum_next  = running_sum + data_byte;
  assign chk_byte  = (~sum_next) + 8'd1;
  assign group_end = ({1'b0, group_count} + 5'd1) >= eff_size;
  assign beat_last = (remaining == fskenc_pkg::CNT_W'(1));

  // Frame shift register, beat counter and check state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      remaining   <= '0;
      with_check  <= 1'b0;
      running_sum <= '0;
      group_count <= '0;
    end else if (load) begin
      busy <= 1'b1;
      if (req_type == fskenc_pkg::REQ_IDLE) begin
        // One mark bit; the sum and the group are left alone.
        frame      <= fskenc_pkg::MAX_BEATS'(1);
        remaining  <= fskenc_pkg::CNT_W'(1);
        with_check <= 1'b0;
      end else begin
        frame     <= {2'b11, chk_byte, 1'b0, 2'b11, data_byte, 1'b0};
        with_check <= group_end;
        if (group_end) begin
          remaining   <= fskenc_pkg::CNT_W'(fskenc_pkg::MAX_BEATS);
          running_sum <= '0;
          group_count <= '0;
        end else begin
          remaining   <= fskenc_pkg::CNT_W'(fskenc_pkg::FRAME_BITS);
          running_sum <= sum_next;
          group_count <= group_count + 4'd1;
        end
      end
    end else if (advance) begin
      frame     <= frame >> 1;
      remaining <= remaining - fskenc_pkg::CNT_W'(1);
      if (beat_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Current beat from the head of the frame.
  always_comb begin
    beat.tone_bit       = frame[0];
    beat.sample_pattern = frame[0] ? fskenc_pkg::ONE_PATTERN : fskenc_pkg::ZERO_PATTERN;
    beat.is_check_byte  = with_check &&
                          (remaining <= fskenc_pkg::CNT_W'(fskenc_pkg::FRAME_BITS));
    beat.last           = beat_last;
  end

  assign status.busy      = busy;
  assign status.remaining = remaining;

endmodule

// ===== sv/fskenc_out_stage.sv =====
// ---------------------------------------------------------------------------
// FSK encoder output register
// Holds one result beat toward the stream receiver.
// ---------------------------------------------------------------------------
module fskenc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat_valid,
  input  fskenc_pkg::beat_t beat,
  output logic              beat_ready,
  output logic              out_valid,
  output fskenc_pkg::beat_t out_beat,
  input  logic              out_ready
);

  // The register can take a beat when empty or being drained.
  assign beat_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_ready) begin
      out_valid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      out_beat <= beat;
    end
  end

endmodule

// ===== sv/fsk_tape_byte_encoder_core.sv =====
// ---------------------------------------------------------------------------
// FSK tape byte encoder core
// Kansas City style cassette encoder: one 32-sample tone pattern per line bit.
// ---------------------------------------------------------------------------
// Usage:
// Requests enter on the s_axis channel: tuser is the request kind (0 = data
// byte, 1 = one idle mark bit), tdata the byte. Results leave on m_axis, one
// beat per line bit: tdata[31:0] is the sample pattern (bit k = sample k),
// tdata[32] the line bit, tuser the check byte flag, tlast the final beat of
// a request. The cfg channel writes the check group size; write it only while the
// block is idle, which the block itself leaves unenforced; cfg_ready is always high.
// Throughput: while m_axis_tready is high the serializer emits one beat per
// cycle; a data byte is 11 beats, 22 when it closes a check group, an idle request 1.
// A one-entry input register lets the next request wait while the current
// one is serialized; the serializer reloads in the cycle its last beat moves,
// and the input register takes a new request in that same cycle.
// On an empty block the first beat of a request passes through the input register,
// the serializer and the output register before it reaches m_axis.
// Reset clears the running sum, the group count and all valid flags and sets
// the group size to 4. When m_axis_tready is low the output register holds
// its beat and the serializer and input register stall behind it.
// ---------------------------------------------------------------------------
`include "fsk_tape_byte_encoder_core_defines.svh"

module fsk_tape_byte_encoder_core (
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] req_type
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] sample_pattern, [32] tone_bit, [39:33] zero
  output logic        m_axis_tuser,   // [0] is_check_byte
  output logic        m_axis_tlast,   // last
  // Configuration write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data        // check_group_size
);

  logic [fskenc_pkg::SIZE_W-1:0] check_group_size;
  logic                          in_valid;
  logic                          in_req;
  logic [7:0]                    in_byte;
  logic                          load;
  logic                          advance;
  logic                          beat_ready;
  fskenc_pkg::ser_status_t       status;
  fskenc_pkg::beat_t             beat;
  fskenc_pkg::beat_t             out_beat;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_group_size <= fskenc_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      check_group_size <= cfg_data;
    end
  end

  // Input register, one request deep; it refills in the cycle it empties.
  assign s_axis_tready = !in_valid || load;
  assign advance       = status.busy && beat_ready;
  assign load          = in_valid && (!status.busy || (advance && beat.last));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  // Framing and check byte serializer.
  fskenc_serializer u_serializer (
    .clk              (clk),
    .rst              (rst),
    .check_group_size (check_group_size),
    .load             (load),
    .req_type         (in_req),
    .data_byte        (in_byte),
    .advance          (advance),
    .status           (status),
    .beat             (beat)
  );

  // Output register.
  fskenc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (status.busy),
    .beat       (beat),
    .beat_ready (beat_ready),
    .out_valid  (m_axis_tvalid),
    .out_beat   (out_beat),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {7'd0, out_beat.tone_bit, out_beat.sample_pattern};
  assign m_axis_tuser = out_beat.is_check_byte;
  assign m_axis_tlast = out_beat.last;

  // The serializer is busy exactly while beats remain.
  `FSKENC_ASSERT_NOW(a_busy_count, 1'b1, status.busy == (status.remaining != '0), "busy flag and beat count disagree")
  // A loaded request always starts the serializer.
  `FSKENC_ASSERT_NEXT(a_load_busy, load, status.busy, "serializer idle after load")
  // An accepted request always lands in the input register.
  `FSKENC_ASSERT_NEXT(a_in_full, s_axis_tvalid && s_axis_tready, in_valid, "accepted request lost")
  // Check beats only appear in the second frame of a 22-beat request.
  `FSKENC_ASSERT_NOW(a_check_tail, status.busy && beat.is_check_byte, status.remaining <= fskenc_pkg::CNT_W'(fskenc_pkg::FRAME_BITS), "check beat out of place")

endmodule
